[rtl/mkt_pkg.sv]
// Shared types and constants for the MAC keyed sighting table.
// Holds the table sizing, the entry record, the outcome codes and the
// command and status structs between the controller and the datapath.
package mkt_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned KEY_W    = 48;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CLIENT_W = 8;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned OCC_W    = 6;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OUTCOME_UPDATED  = 2'd0,
    OUTCOME_INSERTED = 2'd1,
    OUTCOME_EVICTED  = 2'd2,
    OUTCOME_REJECTED = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [LEVEL_W-1:0]  level;
    logic [STAMP_W-1:0]  stamp;
    logic [COUNT_W-1:0]  sightings;
    logic [CLIENT_W-1:0] clients;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic start;
    logic rd_en;
    idx_t rd_addr;
    logic eval;
    idx_t eval_idx;
    logic commit;
  } mkt_cmd_t;

  typedef struct packed {
    logic hit;
  } mkt_sts_t;

endpackage

[rtl/mkt_sighting_if.sv]
// Input channel carrying one sighting item per handshake.
// Depends on mkt_pkg for field widths.
interface mkt_sighting_if import mkt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [KEY_W-1:0]           mac_key;
  logic signed [LEVEL_W-1:0]  signal_level;
  logic [STAMP_W-1:0]         seen_time;
  logic [COUNT_W-1:0]         initial_sightings;
  logic [CLIENT_W-1:0]        clients_seen;

  modport source (output valid, mac_key, signal_level, seen_time, initial_sightings,
                  clients_seen, input ready);
  modport sink   (input valid, mac_key, signal_level, seen_time, initial_sightings,
                  clients_seen, output ready);
endinterface

[rtl/mkt_result_if.sv]
// Output channel carrying one result item per handshake.
// Depends on mkt_pkg for field widths and the outcome codes.
interface mkt_result_if import mkt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  outcome_e                   outcome;
  logic [SLOT_W-1:0]          slot;
  logic [COUNT_W-1:0]         sightings_now;
  logic [CLIENT_W-1:0]        clients_now;
  logic [KEY_W-1:0]           evicted_key;
  logic signed [LEVEL_W-1:0]  evicted_level;
  logic [OCC_W-1:0]           occupancy;

  modport source (output valid, outcome, slot, sightings_now, clients_now, evicted_key,
                  evicted_level, occupancy, input ready);
  modport sink   (input valid, outcome, slot, sightings_now, clients_now, evicted_key,
                  evicted_level, occupancy, output ready);
endinterface

[rtl/mac_keyed_table_weakest_evict.sv]
// Top level of the MAC keyed sighting table with weakest-entry replacement.
// Depends on mkt_pkg, mkt_sighting_if, mkt_result_if, mkt_ctrl and mkt_dp.
//
//   Channel    Dir  Handshake              Item
//   sight_i    in   sight_i.valid/ready    mac_key, signal_level, seen_time,
//                                          initial_sightings, clients_seen
//   result_o   out  result_o.valid/ready   outcome, slot, sightings_now, clients_now,
//                                          evicted_key, evicted_level, occupancy
//
// An item is accepted in the idle state and then walks the entry RAM one slot per
// cycle, one read each cycle through its single read port. A key hit ends the walk
// early; a miss or full-table eviction walks every slot. Reset clears the valid bits,
// the entry count and the scan flags; the entry RAM needs no clearing pass because
// the read data of a slot is used only once its valid bit is set.
// The result sits in its own register, so the next item is accepted while the previous
// result waits; only the commit step waits for that register to be taken.
module mac_keyed_table_weakest_evict import mkt_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  mkt_sighting_if.sink  sight_i,
  mkt_result_if.source  result_o
);

  mkt_cmd_t cmd;
  mkt_sts_t sts;

  // The controller owns the handshakes and the walk over the slots.
  mkt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sight_i.valid),
    .in_ready_o  (sight_i.ready),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the table, the search state and the result register.
  mkt_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .mac_key_i           (sight_i.mac_key),
    .signal_level_i      (sight_i.signal_level),
    .seen_time_i         (sight_i.seen_time),
    .initial_sightings_i (sight_i.initial_sightings),
    .clients_seen_i      (sight_i.clients_seen),
    .outcome_o           (result_o.outcome),
    .slot_o              (result_o.slot),
    .sightings_now_o     (result_o.sightings_now),
    .clients_now_o       (result_o.clients_now),
    .evicted_key_o       (result_o.evicted_key),
    .evicted_level_o     (result_o.evicted_level),
    .occupancy_o         (result_o.occupancy)
  );

endmodule

[rtl/mkt_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package dependency.
module mkt_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 32,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mkt_ctrl.sv]
// Sequencer for the sighting table: accepts an item, walks the table addresses,
// then commits the result. Depends on mkt_pkg for the command and status structs.
module mkt_ctrl import mkt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  input  mkt_sts_t sts_i,
  output mkt_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  cnt_t   cnt_q, cnt_d;
  logic   ev_q, ev_d;
  idx_t   ev_idx_q, ev_idx_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          cnt_d       = '0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en    = (cnt_q < CNT_W'(TABLE_DEPTH));
        cmd_o.rd_addr  = cnt_q[IDX_W-1:0];
        cmd_o.eval     = ev_q;
        cmd_o.eval_idx = ev_idx_q;
        if (cmd_o.rd_en) begin
          cnt_d = cnt_q + 1'b1;
        end
        // A key hit ends the walk early; otherwise every slot is looked at.
        if ((ev_q && sts_i.hit) || !cmd_o.rd_en) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    ev_d     = cmd_o.rd_en;
    ev_idx_d = cmd_o.rd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ev_q        <= 1'b0;
      ev_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ev_q        <= ev_d;
      ev_idx_q    <= ev_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= CNT_W'(TABLE_DEPTH)))
    else $error("scan counter ran past the table");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_COMMIT))
    else $error("result raised outside the commit step");

endmodule

[rtl/mkt_dp.sv]
// Datapath of the sighting table: entry RAM, valid bits, age ranks, scan
// trackers and the result register. Depends on mkt_pkg and mkt_ram.
module mkt_dp import mkt_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mkt_cmd_t                   cmd_i,
  output mkt_sts_t                   sts_o,
  input  logic [KEY_W-1:0]           mac_key_i,
  input  logic signed [LEVEL_W-1:0]  signal_level_i,
  input  logic [STAMP_W-1:0]         seen_time_i,
  input  logic [COUNT_W-1:0]         initial_sightings_i,
  input  logic [CLIENT_W-1:0]        clients_seen_i,
  output outcome_e                   outcome_o,
  output logic [SLOT_W-1:0]          slot_o,
  output logic [COUNT_W-1:0]         sightings_now_o,
  output logic [CLIENT_W-1:0]        clients_now_o,
  output logic [KEY_W-1:0]           evicted_key_o,
  output logic signed [LEVEL_W-1:0]  evicted_level_o,
  output logic [OCC_W-1:0]           occupancy_o
);

  // Latched item.
  logic [KEY_W-1:0]          in_key_q;
  logic signed [LEVEL_W-1:0] in_level_q;
  logic [STAMP_W-1:0]        in_stamp_q;
  logic [COUNT_W-1:0]        in_init_q;
  logic [CLIENT_W-1:0]       in_clients_q;

  // Table bookkeeping.
  logic [TABLE_DEPTH-1:0] valid_q;
  idx_t                   rank_q [TABLE_DEPTH];
  cnt_t                   total_q;

  // Scan trackers.
  logic                      hit_q, free_found_q, weak_found_q;
  idx_t                      hit_slot_q, free_slot_q, weak_slot_q, weak_rank_q;
  logic [COUNT_W-1:0]        hit_sight_q;
  logic [CLIENT_W-1:0]       hit_clients_q;
  logic [KEY_W-1:0]          weak_key_q;
  logic signed [LEVEL_W-1:0] weak_level_q;

  // Result register.
  outcome_e                  res_outcome_q;
  logic [SLOT_W-1:0]         res_slot_q;
  logic [COUNT_W-1:0]        res_sight_q;
  logic [CLIENT_W-1:0]       res_clients_q;
  logic [KEY_W-1:0]          res_ev_key_q;
  logic signed [LEVEL_W-1:0] res_ev_level_q;
  logic [OCC_W-1:0]          res_occ_q;

  logic [ENTRY_W-1:0]        rdata;
  entry_t                    rec;
  logic                      ev_valid;
  idx_t                      ev_rank;
  logic signed [LEVEL_W-1:0] ev_level;
  logic                      key_match, weaker;

  // Commit decision.
  outcome_e                  outcome;
  logic                      wr_en, do_insert, do_evict;
  idx_t                      wr_slot;
  logic [COUNT_W-1:0]        new_sight;
  logic [CLIENT_W-1:0]       new_clients;
  logic [KEY_W-1:0]          ev_key;
  logic signed [LEVEL_W-1:0] ev_lvl_out;
  cnt_t                      total_d;
  entry_t                    wr_rec;

  mkt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && wr_en),
    .waddr_i (wr_slot),
    .wdata_i (wr_rec),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rdata)
  );

  assign rec       = entry_t'(rdata);
  assign ev_valid  = valid_q[cmd_i.eval_idx];
  assign ev_rank   = rank_q[cmd_i.eval_idx];
  assign ev_level  = $signed(rec.level);
  assign key_match = cmd_i.eval && ev_valid && (rec.key == in_key_q);
  assign sts_o.hit = key_match;

  // Lower level wins; on equal level the older insertion wins.
  assign weaker = !weak_found_q || (ev_level < weak_level_q) ||
                  ((ev_level == weak_level_q) && (ev_rank < weak_rank_q));

  always_comb begin
    outcome     = OUTCOME_REJECTED;
    wr_en       = 1'b0;
    do_insert   = 1'b0;
    do_evict    = 1'b0;
    wr_slot     = '0;
    new_sight   = '0;
    new_clients = '0;
    ev_key      = '0;
    ev_lvl_out  = '0;
    total_d     = total_q;
    if (hit_q) begin
      outcome     = OUTCOME_UPDATED;
      wr_en       = 1'b1;
      wr_slot     = hit_slot_q;
      new_sight   = hit_sight_q + 1'b1;
      new_clients = (in_clients_q != '0) ? in_clients_q : hit_clients_q;
    end else if (total_q < CNT_W'(TABLE_DEPTH)) begin
      outcome     = OUTCOME_INSERTED;
      wr_en       = 1'b1;
      do_insert   = 1'b1;
      wr_slot     = free_slot_q;
      new_sight   = in_init_q;
      new_clients = in_clients_q;
      total_d     = total_q + 1'b1;
    end else if (weak_found_q && (weak_level_q < in_level_q)) begin
      outcome     = OUTCOME_EVICTED;
      wr_en       = 1'b1;
      do_evict    = 1'b1;
      wr_slot     = weak_slot_q;
      new_sight   = in_init_q;
      new_clients = in_clients_q;
      ev_key      = weak_key_q;
      ev_lvl_out  = weak_level_q;
    end
    wr_rec.key       = in_key_q;
    wr_rec.level     = in_level_q;
    wr_rec.stamp     = in_stamp_q;
    wr_rec.sightings = new_sight;
    wr_rec.clients   = new_clients;
  end

  // Item latch and result register carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      in_key_q     <= mac_key_i;
      in_level_q   <= signal_level_i;
      in_stamp_q   <= seen_time_i;
      in_init_q    <= initial_sightings_i;
      in_clients_q <= clients_seen_i;
    end
    if (key_match) begin
      hit_slot_q    <= cmd_i.eval_idx;
      hit_sight_q   <= rec.sightings;
      hit_clients_q <= rec.clients;
    end
    if (cmd_i.eval && !ev_valid && !free_found_q) begin
      free_slot_q <= cmd_i.eval_idx;
    end
    if (cmd_i.eval && ev_valid && weaker) begin
      weak_slot_q  <= cmd_i.eval_idx;
      weak_key_q   <= rec.key;
      weak_level_q <= ev_level;
      weak_rank_q  <= ev_rank;
    end
    if (cmd_i.commit) begin
      res_outcome_q  <= outcome;
      res_slot_q     <= (outcome == OUTCOME_REJECTED) ? '0 : SLOT_W'(wr_slot);
      res_sight_q    <= new_sight;
      res_clients_q  <= new_clients;
      res_ev_key_q   <= ev_key;
      res_ev_level_q <= ev_lvl_out;
      res_occ_q      <= OCC_W'(total_d);
    end
  end

  // Age ranks: the newcomer is always the youngest; on eviction everything
  // younger than the victim moves up one place.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cmd_i.commit && do_insert && (free_slot_q == IDX_W'(i))) begin
        rank_q[i] <= total_q[IDX_W-1:0];
      end else if (cmd_i.commit && do_evict && (weak_slot_q == IDX_W'(i))) begin
        rank_q[i] <= IDX_W'(TABLE_DEPTH - 1);
      end else if (cmd_i.commit && do_evict && valid_q[i] && (rank_q[i] > weak_rank_q)) begin
        rank_q[i] <= rank_q[i] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      total_q      <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      weak_found_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
        weak_found_q <= 1'b0;
      end else begin
        if (key_match) begin
          hit_q <= 1'b1;
        end
        if (cmd_i.eval && !ev_valid) begin
          free_found_q <= 1'b1;
        end
        if (cmd_i.eval && ev_valid) begin
          weak_found_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        total_q <= total_d;
        if (do_insert) begin
          valid_q[free_slot_q] <= 1'b1;
        end
      end
    end
  end

  assign outcome_o       = res_outcome_q;
  assign slot_o          = res_slot_q;
  assign sightings_now_o = res_sight_q;
  assign clients_now_o   = res_clients_q;
  assign evicted_key_o   = res_ev_key_q;
  assign evicted_level_o = res_ev_level_q;
  assign occupancy_o     = res_occ_q;

  a_total_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'($countones(valid_q)) == total_q)
    else $error("entry count disagrees with valid bits");

  a_insert_has_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !hit_q && (total_q < CNT_W'(TABLE_DEPTH))) |-> free_found_q)
    else $error("insert without a free slot found");

endmodule

[tb/tb_top.sv]
// Self-checking bench for the MAC keyed sighting table with weakest-entry replacement.
// Depends on mkt_pkg, mkt_sighting_if, mkt_result_if and mac_keyed_table_weakest_evict.
// Directed rows run first, then random sightings; the model checks all but typed rows.
module tb_top;
  import mkt_pkg::*;

  // The receiver holds off this long once, so that the result register fills and the
  // block stops taking sightings.
  localparam int unsigned HOLD_CYCLES   = 300;
  // Cycles without any accepted item before the run is declared hung. The slowest
  // legal gap is one full table walk plus random idling on both sides, or the hold-off.
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 1510;
  // Two full walks of the table cover any result still in flight at the end.
  localparam int unsigned SETTLE_CYCLES = 2 * (TABLE_DEPTH + 3);
  // Twice the table depth, so that random keys keep the table full and churning.
  localparam int unsigned POOL_SIZE     = 2 * TABLE_DEPTH;
  localparam logic [KEY_W-1:0] FILL_KEY_BASE = 48'h0000_A000_0000;

  typedef struct packed {
    logic [KEY_W-1:0]           mac_key;
    logic signed [LEVEL_W-1:0]  signal_level;
    logic [STAMP_W-1:0]         seen_time;
    logic [COUNT_W-1:0]         initial_sightings;
    logic [CLIENT_W-1:0]        clients_seen;
  } sighting_t;

  typedef struct packed {
    outcome_e                   outcome;
    logic [SLOT_W-1:0]          slot;
    logic [COUNT_W-1:0]         sightings_now;
    logic [CLIENT_W-1:0]        clients_now;
    logic [KEY_W-1:0]           evicted_key;
    logic signed [LEVEL_W-1:0]  evicted_level;
    logic [OCC_W-1:0]           occupancy;
  } table_result_t;

  // A directed row either carries its result typed in, leaves it to the table model,
  // or stands for a run of filler sightings that brings the table to full.
  typedef enum logic [1:0] {
    ROW_TYPED,
    ROW_PREDICTED,
    ROW_FILL
  } row_kind_e;

  typedef struct {
    row_kind_e     kind;
    sighting_t     s;
    table_result_t want;
  } directed_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mkt_sighting_if sighting_ch ();
  mkt_result_if   result_ch ();

  mac_keyed_table_weakest_evict u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sight_i  (sighting_ch),
    .result_o (result_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Table model: its own copy of every entry, the insertion rank and the entry count.
  logic                      stored_valid     [TABLE_DEPTH];
  logic [KEY_W-1:0]          stored_key       [TABLE_DEPTH];
  logic signed [LEVEL_W-1:0] stored_level     [TABLE_DEPTH];
  logic [STAMP_W-1:0]        stored_stamp     [TABLE_DEPTH];
  logic [COUNT_W-1:0]        stored_sightings [TABLE_DEPTH];
  logic [CLIENT_W-1:0]       stored_clients   [TABLE_DEPTH];
  int unsigned               stored_rank      [TABLE_DEPTH];
  int unsigned               stored_count;

  logic [KEY_W-1:0]  key_pool [POOL_SIZE];
  directed_row_t     directed_rows [$];
  table_result_t     awaited_results [$];

  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned sightings_sent;
  int unsigned outcome_tally [4];
  bit          steady;
  bit          hold_request;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got_v,
                             input logic [63:0] want_v);
    if (got_v !== want_v) begin
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                results_checked, name, got_v, want_v));
    end
  endtask

  function automatic void store_entry(int slot_no, sighting_t s, int unsigned rank);
    stored_valid[slot_no]     = 1'b1;
    stored_key[slot_no]       = s.mac_key;
    stored_level[slot_no]     = s.signal_level;
    stored_stamp[slot_no]     = s.seen_time;
    stored_sightings[slot_no] = s.initial_sightings;
    stored_clients[slot_no]   = s.clients_seen;
    stored_rank[slot_no]      = rank;
  endfunction

  // Folds one sighting into the table model and returns the result it must cause.
  function automatic table_result_t fold_sighting(sighting_t s);
    table_result_t             r;
    logic signed [LEVEL_W-1:0] lvl;
    int                        hit;
    int                        free_slot;
    int                        weakest;
    r         = '0;
    r.outcome = OUTCOME_REJECTED;
    lvl       = s.signal_level;
    hit       = -1;
    free_slot = -1;
    weakest   = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit < 0 && stored_valid[i] && stored_key[i] == s.mac_key) hit = i;
    end
    if (hit >= 0) begin
      // Known key: level and time follow the sighting, the count wraps at 32 bits,
      // and a zero client count leaves the stored one alone.
      stored_level[hit]     = lvl;
      stored_stamp[hit]     = s.seen_time;
      stored_sightings[hit] = stored_sightings[hit] + 1'b1;
      if (s.clients_seen != '0) stored_clients[hit] = s.clients_seen;
      r.outcome       = OUTCOME_UPDATED;
      r.slot          = SLOT_W'(hit);
      r.sightings_now = stored_sightings[hit];
      r.clients_now   = stored_clients[hit];
    end else if (stored_count < TABLE_DEPTH) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (free_slot < 0 && !stored_valid[i]) free_slot = i;
      end
      store_entry(free_slot, s, stored_count);
      stored_count++;
      r.outcome       = OUTCOME_INSERTED;
      r.slot          = SLOT_W'(free_slot);
      r.sightings_now = s.initial_sightings;
      r.clients_now   = s.clients_seen;
    end else begin
      // Full table: the weakest entry, oldest first among equals, goes only when it
      // is strictly weaker than the newcomer.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (stored_valid[i] && (weakest < 0 || stored_level[i] < stored_level[weakest] ||
            (stored_level[i] == stored_level[weakest] &&
             stored_rank[i] < stored_rank[weakest]))) begin
          weakest = i;
        end
      end
      if (weakest >= 0 && stored_level[weakest] < lvl) begin
        r.evicted_key   = stored_key[weakest];
        r.evicted_level = stored_level[weakest];
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (stored_valid[i] && stored_rank[i] > stored_rank[weakest]) stored_rank[i]--;
        end
        store_entry(weakest, s, stored_count - 1);
        r.outcome       = OUTCOME_EVICTED;
        r.slot          = SLOT_W'(weakest);
        r.sightings_now = s.initial_sightings;
        r.clients_now   = s.clients_seen;
      end
    end
    r.occupancy = OCC_W'(stored_count);
    return r;
  endfunction

  function automatic sighting_t sighting_of(logic [KEY_W-1:0] key,
                                            logic signed [LEVEL_W-1:0] level,
                                            logic [STAMP_W-1:0] stamp,
                                            logic [COUNT_W-1:0] init,
                                            logic [CLIENT_W-1:0] clients);
    sighting_t s;
    s.mac_key           = key;
    s.signal_level      = level;
    s.seen_time         = stamp;
    s.initial_sightings = init;
    s.clients_seen      = clients;
    return s;
  endfunction

  function automatic table_result_t table_result_of(outcome_e o, int unsigned slot_no,
                                                    logic [COUNT_W-1:0] sightings,
                                                    logic [CLIENT_W-1:0] clients,
                                                    logic [KEY_W-1:0] ev_key,
                                                    logic signed [LEVEL_W-1:0] ev_level,
                                                    int unsigned occ);
    table_result_t r;
    r.outcome       = o;
    r.slot          = SLOT_W'(slot_no);
    r.sightings_now = sightings;
    r.clients_now   = clients;
    r.evicted_key   = ev_key;
    r.evicted_level = ev_level;
    r.occupancy     = OCC_W'(occ);
    return r;
  endfunction

  task automatic add_row(input row_kind_e kind, input sighting_t s,
                         input table_result_t want);
    directed_row_t row;
    row.kind = kind;
    row.s    = s;
    row.want = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Most keys come from a pool twice the table size, so hits, evictions and
  // rejections all stay frequent; the rest are fresh, single-bit or uniform keys.
  function automatic sighting_t random_sighting();
    sighting_t   s;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) s.mac_key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else if (pick < 85) s.mac_key = KEY_W'({$urandom(), $urandom()});
    else if (pick < 92) s.mac_key = KEY_W'(1) << $urandom_range(KEY_W - 1);
    else s.mac_key = {KEY_W{pick[0]}};
    pick = $urandom_range(9);
    if (pick == 0) s.signal_level = 8'sh80;
    else if (pick == 1) s.signal_level = 8'sh7F;
    else s.signal_level = LEVEL_W'($urandom());
    s.seen_time = $urandom();
    pick = $urandom_range(9);
    if (pick == 0) s.initial_sightings = '1;
    else if (pick == 1) s.initial_sightings = '0;
    else s.initial_sightings = $urandom();
    if ($urandom_range(99) < 30) s.clients_seen = '0;
    else s.clients_seen = CLIENT_W'($urandom_range(255));
    return s;
  endfunction

  // Offers one sighting from a falling edge until it is taken, with random idle
  // cycles in front, then records the result it must cause. Returns at a falling edge.
  task automatic send_sighting(input sighting_t s, input row_kind_e kind,
                               input table_result_t typed_result);
    table_result_t predicted;
    while (!steady && $urandom_range(99) < 33) begin
      sighting_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    sighting_ch.valid             <= 1'b1;
    sighting_ch.mac_key           <= s.mac_key;
    sighting_ch.signal_level      <= s.signal_level;
    sighting_ch.seen_time         <= s.seen_time;
    sighting_ch.initial_sightings <= s.initial_sightings;
    sighting_ch.clients_seen      <= s.clients_seen;
    do @(posedge clk_i); while (!sighting_ch.ready);
    predicted = fold_sighting(s);
    awaited_results.insert(awaited_results.size(),
                           (kind == ROW_TYPED) ? typed_result : predicted);
    sightings_sent++;
    @(negedge clk_i);
  endtask

  // Stops offering until every awaited result has come back. At least one edge
  // passes, so that valid is never assigned twice in the same step.
  task automatic wait_for_drain();
    sighting_ch.valid <= 1'b0;
    do @(negedge clk_i); while (awaited_results.size() != 0);
  endtask

  // Receiver: random back-pressure, none while the steady stretch runs, and one
  // long hold-off counted here when the stimulus asks for it.
  initial begin : result_receiver
    int unsigned hold_left;
    hold_left       = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= steady || ($urandom_range(99) >= 33);
      end
    end
  end

  // Every taken result is compared field by field with the oldest awaited one.
  always @(posedge clk_i) begin : result_check
    table_result_t got;
    table_result_t want;
    if (result_ch.valid && result_ch.ready) begin
      got.outcome       = result_ch.outcome;
      got.slot          = result_ch.slot;
      got.sightings_now = result_ch.sightings_now;
      got.clients_now   = result_ch.clients_now;
      got.evicted_key   = result_ch.evicted_key;
      got.evicted_level = result_ch.evicted_level;
      got.occupancy     = result_ch.occupancy;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing awaited",
                                  results_checked));
      end else begin
        want = awaited_results.pop_front();
        check_field("outcome", got.outcome, want.outcome);
        check_field("slot", got.slot, want.slot);
        check_field("sightings_now", got.sightings_now, want.sightings_now);
        check_field("clients_now", got.clients_now, want.clients_now);
        check_field("evicted_key", got.evicted_key, want.evicted_key);
        check_field("evicted_level", got.evicted_level, want.evicted_level);
        check_field("occupancy", got.occupancy, want.occupancy);
      end
      if (!$isunknown(got.outcome)) outcome_tally[got.outcome]++;
      results_checked++;
    end
  end

  // Watchdog: ends the run when no item moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((sighting_ch.valid && sighting_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, awaited_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned fill_no;
    fill_no                       = 0;
    mismatches                    = 0;
    results_checked               = 0;
    sightings_sent                = 0;
    steady                        = 1'b0;
    hold_request                  = 1'b0;
    sighting_ch.valid             = 1'b0;
    sighting_ch.mac_key           = '0;
    sighting_ch.signal_level      = '0;
    sighting_ch.seen_time         = '0;
    sighting_ch.initial_sightings = '0;
    sighting_ch.clients_seen      = '0;
    stored_count                  = 0;
    foreach (outcome_tally[i]) outcome_tally[i] = 0;
    foreach (stored_valid[i]) stored_valid[i] = 1'b0;
    foreach (key_pool[i]) key_pool[i] = KEY_W'({$urandom(), $urandom()});

    // Empty table: the first insert carries every field at its low extreme,
    // the second at its high extreme.
    add_row(ROW_TYPED, sighting_of('0, -128, '0, '0, '0),
            table_result_of(OUTCOME_INSERTED, 0, '0, '0, '0, 0, 1));
    add_row(ROW_TYPED, sighting_of('1, 127, '1, '1, '1),
            table_result_of(OUTCOME_INSERTED, 1, '1, '1, '0, 0, 2));
    // A hit on an all-ones count wraps it to zero; a zero client count keeps 255.
    add_row(ROW_TYPED, sighting_of('1, 127, 32'd1, 32'd5, '0),
            table_result_of(OUTCOME_UPDATED, 1, '0, '1, '0, 0, 2));
    // A hit with a nonzero client count replaces the stored one.
    add_row(ROW_TYPED, sighting_of('0, -128, 32'd2, 32'd3, 8'd9),
            table_result_of(OUTCOME_UPDATED, 0, 32'd1, 8'd9, '0, 0, 2));
    // Keys one bit away from stored keys must miss and take the next free slots.
    add_row(ROW_TYPED, sighting_of(48'h8000_0000_0000, 0, 32'd3, 32'h8000_0000, 8'h80),
            table_result_of(OUTCOME_INSERTED, 2, 32'h8000_0000, 8'h80, '0, 0, 3));
    add_row(ROW_TYPED, sighting_of(48'h7FFF_FFFF_FFFF, 0, 32'd4, 32'h7FFF_FFFF, 8'h7F),
            table_result_of(OUTCOME_INSERTED, 3, 32'h7FFF_FFFF, 8'h7F, '0, 0, 4));
    add_row(ROW_TYPED, sighting_of(48'd1, 0, 32'd5, 32'd1, 8'd1),
            table_result_of(OUTCOME_INSERTED, 4, 32'd1, 8'd1, '0, 0, 5));
    // Level-zero fillers, all younger than the entries above, bring the table to full.
    add_row(ROW_FILL, '0, '0);
    // A newcomer as weak as the weakest entry is turned away.
    add_row(ROW_TYPED, sighting_of(48'd2, -128, 32'd6, 32'd50, 8'd6),
            table_result_of(OUTCOME_REJECTED, 0, '0, '0, '0, 0, TABLE_DEPTH));
    // One step stronger evicts it; a zero client count is stored as zero.
    add_row(ROW_TYPED, sighting_of(48'd3, -127, 32'd7, 32'd100, '0),
            table_result_of(OUTCOME_EVICTED, 0, 32'd100, '0, '0, -128, TABLE_DEPTH));
    add_row(ROW_TYPED, sighting_of(48'd4, -127, 32'd8, 32'd60, 8'd2),
            table_result_of(OUTCOME_REJECTED, 0, '0, '0, '0, 0, TABLE_DEPTH));
    add_row(ROW_TYPED, sighting_of(48'd5, 1, 32'd9, 32'd7, 8'd3),
            table_result_of(OUTCOME_EVICTED, 0, 32'd7, 8'd3, 48'd3, -127, TABLE_DEPTH));
    // Ties at level zero: the oldest inserted goes first, then the next oldest.
    add_row(ROW_TYPED, sighting_of(48'd6, 1, 32'd10, 32'd9, '0),
            table_result_of(OUTCOME_EVICTED, 2, 32'd9, '0, 48'h8000_0000_0000, 0,
                            TABLE_DEPTH));
    add_row(ROW_TYPED, sighting_of(48'd7, 1, 32'd11, 32'd10, 8'd4),
            table_result_of(OUTCOME_EVICTED, 3, 32'd10, 8'd4, 48'h7FFF_FFFF_FFFF, 0,
                            TABLE_DEPTH));
    // An update in a full table weakens the all-ones key, and the next newcomer takes it.
    add_row(ROW_TYPED, sighting_of('1, -5, 32'd12, '0, '0),
            table_result_of(OUTCOME_UPDATED, 1, 32'd1, '1, '0, 0, TABLE_DEPTH));
    add_row(ROW_TYPED, sighting_of(48'd2, 127, 32'd13, 32'd11, 8'd5),
            table_result_of(OUTCOME_EVICTED, 1, 32'd11, 8'd5, '1, -5, TABLE_DEPTH));
    add_row(ROW_PREDICTED, sighting_of('0, 0, 32'd14, 32'd12, '0), '0);

    // Reset is released at a falling edge.
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_FILL) begin
        while (stored_count < TABLE_DEPTH) begin
          send_sighting(sighting_of(FILL_KEY_BASE + fill_no, 0, $urandom(), $urandom(),
                                    CLIENT_W'($urandom())), ROW_PREDICTED, '0);
          fill_no++;
        end
      end else begin
        send_sighting(directed_rows[r].s, directed_rows[r].kind, directed_rows[r].want);
      end
    end

    // Random part: a drained pause, a stretch with no idling on either side, and a
    // long receiver hold-off while sightings keep coming.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 500 && n < 700);
      if (n == 300) wait_for_drain();
      if (n == 900) hold_request = 1'b1;
      send_sighting(random_sighting(), ROW_PREDICTED, '0);
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    while (awaited_results.size() != 0) begin
      report_mismatch("result still awaited at the end of the run");
      void'(awaited_results.pop_front());
    end

    $display("Sent %0d sightings, checked %0d results: %0d updates, %0d free inserts,",
             sightings_sent, results_checked, outcome_tally[OUTCOME_UPDATED],
             outcome_tally[OUTCOME_INSERTED]);
    $display("%0d evictions, %0d rejections, with back-pressure and a drained pause;",
             outcome_tally[OUTCOME_EVICTED], outcome_tally[OUTCOME_REJECTED]);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
